/* hw/rtl/mi3_pkg.sv */
// mi3_pkg: shared constants and types of the 3x3 inverse / determinant core
// no dependencies; imported by every module of the block

package mi3_pkg;

	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_ENTRIES     = 9;
	// queue between front and back, power of two
	localparam int FIFO_DEPTH      = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_st_t;

endpackage

/* hw/rtl/mi3_fifo.sv */
// mi3_fifo: short register queue between the front and back pipelines
// depends on mi3_pkg for the status struct

module mi3_fifo
	import mi3_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output fifo_st_t         st
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [PW:0]      cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout     = mem_q[rp_q];
	assign st.full  = (cnt_q == (PW+1)'(DEPTH));
	assign st.empty = (cnt_q == '0);

endmodule

/* hw/rtl/mi3_front.sv */
// mi3_front: adjugate and exact determinant pipeline, singular detection
// depends on mi3_pkg; feeds one packed item per matrix into mi3_fifo

module mi3_front
	import mi3_pkg::*;
#(
	parameter int EW = ENTRY_WIDTH_DEF,
	parameter int F  = FRAC_BITS_DEF,
	localparam int AMW  = 2 * EW,
	localparam int DMW  = 3 * EW + 2,
	localparam int DETW = EW + F,
	localparam int LW   = AMW + 1,
	localparam int QIW  = NUM_ENTRIES * LW + DMW + DETW + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [EW-1:0] ent [NUM_ENTRIES],
	input  fifo_st_t             st,
	output logic                 push,
	output logic [QIW-1:0]       item
);

	localparam int AW  = 2 * EW + 1;
	localparam int DFW = 3 * EW + 3;
	localparam logic [DMW-1:0] DLIM_P = (DMW'(1) << (DETW - 1)) - DMW'(1);
	localparam logic [DMW-1:0] DLIM_N = DMW'(1) << (DETW - 1);

	logic [5:0] v_q;
	logic       en;

	logic signed [2*EW-1:0] pp_s1 [NUM_ENTRIES];
	logic signed [2*EW-1:0] pn_s1 [NUM_ENTRIES];
	logic signed [EW-1:0]   row0_s1 [3];
	logic signed [AW-1:0]   adj_s2 [NUM_ENTRIES];
	logic signed [EW-1:0]   row0_s2 [3];
	logic signed [AW-1:0]   adj_s3 [NUM_ENTRIES];
	logic signed [2*EW:0]   pl_s3 [3];
	logic signed [2*EW:0]   ph_s3 [3];
	logic signed [AW-1:0]   adj_s4 [NUM_ENTRIES];
	logic signed [DFW-1:0]  term_s4 [3];
	logic signed [AW-1:0]   adj_s5 [NUM_ENTRIES];
	logic signed [DFW-1:0]  det_s5;
	logic [QIW-1:0]         item_s6;

	assign en       = !(v_q[5] && st.full);
	assign in_stall = !en;
	assign push     = v_q[5] && !st.full;
	assign item     = item_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], in_valid};
		end
	end

	// cofactor products: adj[i][j] = m[j1][i1]*m[j2][i2] - m[j1][i2]*m[j2][i1]
	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_adj
		localparam int I  = g / 3;
		localparam int J  = g % 3;
		localparam int I1 = (I + 1) % 3;
		localparam int I2 = (I + 2) % 3;
		localparam int J1 = (J + 1) % 3;
		localparam int J2 = (J + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				pp_s1[g]  <= ent[J1*3+I1] * ent[J2*3+I2];
				pn_s1[g]  <= ent[J1*3+I2] * ent[J2*3+I1];
				adj_s2[g] <= AW'(pp_s1[g]) - AW'(pn_s1[g]);
				adj_s3[g] <= adj_s2[g];
				adj_s4[g] <= adj_s3[g];
				adj_s5[g] <= adj_s4[g];
			end
		end
	end

	// det = a00*adj00 + a01*adj10 + a02*adj20, adjugate split in two halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				row0_s1[j] <= ent[j];
				row0_s2[j] <= row0_s1[j];
				pl_s3[j]   <= row0_s2[j] * $signed({1'b0, adj_s2[j*3][EW-1:0]});
				ph_s3[j]   <= row0_s2[j] * $signed(adj_s2[j*3][AW-1:EW]);
				term_s4[j] <= (DFW'(ph_s3[j]) <<< EW) + DFW'(pl_s3[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		end
	end

	// classify: magnitudes, signs, singular flag, scaled determinant
	logic                  det_neg;
	logic signed [DFW-1:0] det_abs;
	logic [DMW-1:0]        det_mag;
	logic [DMW-1:0]        det_shr;
	logic [DMW-1:0]        det_lim;
	logic [DMW-1:0]        det_sat;
	logic [DETW-1:0]       det_out;
	logic [QIW-1:0]        item_d;

	always_comb begin
		det_neg = det_s5[DFW-1];
		det_abs = det_neg ? -det_s5 : det_s5;
		det_mag = det_abs[DMW-1:0];
		det_shr = det_mag >> (2 * F);
		det_lim = det_neg ? DLIM_N : DLIM_P;
		det_sat = (det_shr > det_lim) ? det_lim : det_shr;
		det_out = det_neg ? -DETW'(det_sat) : DETW'(det_sat);
		item_d  = '0;
		for (int l = 0; l < NUM_ENTRIES; l++) begin
			item_d[l*LW +: LW] = {adj_s5[l][AW-1],
				AMW'(adj_s5[l][AW-1] ? -adj_s5[l] : adj_s5[l])};
		end
		item_d[NUM_ENTRIES*LW +: DETW]       = det_out;
		item_d[NUM_ENTRIES*LW + DETW +: DMW] = det_mag;
		item_d[QIW-2]                        = det_neg;
		item_d[QIW-1]                        = (det_s5 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s6 <= item_d;
		end
	end

endmodule

/* hw/rtl/mi3_back.sv */
// mi3_back: nine restoring divider lanes, one quotient bit per stage, and saturation
// depends on mi3_pkg; takes packed items from mi3_fifo, drives the result registers

module mi3_back
	import mi3_pkg::*;
#(
	parameter int EW = ENTRY_WIDTH_DEF,
	parameter int F  = FRAC_BITS_DEF,
	localparam int AMW  = 2 * EW,
	localparam int DMW  = 3 * EW + 2,
	localparam int DETW = EW + F,
	localparam int LW   = AMW + 1,
	localparam int QIW  = NUM_ENTRIES * LW + DMW + DETW + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fifo_st_t               st,
	input  logic [QIW-1:0]         item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [EW-1:0]   inv [NUM_ENTRIES],
	output logic signed [DETW-1:0] det_out,
	output logic                   sing
);

	localparam int NW  = AMW + 2 * F;
	localparam int DSW = DMW + EW + 1;
	localparam int CW  = (NW > DSW) ? NW : DSW;
	localparam int QW  = EW + 1;
	localparam int NS  = EW + 2;
	localparam logic [QW-1:0] LIM_P   = (QW'(1) << (EW - 1)) - QW'(1);
	localparam logic [QW-1:0] LIM_N   = QW'(1) << (EW - 1);
	localparam logic [EW-1:0] ONE_VAL =
		(F <= EW - 2) ? (EW'(1) << F) : {1'b0, {(EW-1){1'b1}}};

	logic            en;
	logic [NS-1:0]   vb_q;
	logic [CW-1:0]   rem_q  [NS][NUM_ENTRIES];
	logic [QW-1:0]   quo_q  [NS][NUM_ENTRIES];
	logic            ovf_q  [NS][NUM_ENTRIES];
	logic            neg_q  [NS][NUM_ENTRIES];
	logic [DMW-1:0]  dmag_q [NS];
	logic [DETW-1:0] dout_q [NS];
	logic            sing_q [NS];
	logic            ov_q;
	logic [EW-1:0]   inv_q  [NUM_ENTRIES];
	logic [DETW-1:0] det_q;
	logic            sout_q;

	logic [DMW-1:0] in_dmag;
	logic           in_dneg;

	assign en      = !(ov_q && out_stall);
	assign pop     = en && !st.empty;
	assign in_dmag = item[NUM_ENTRIES*LW + DETW +: DMW];
	assign in_dneg = item[QIW-2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= '0;
			ov_q <= 1'b0;
		end else if (en) begin
			vb_q <= {vb_q[NS-2:0], !st.empty};
			ov_q <= vb_q[NS-1];
		end
	end

	// load stage: numerator is |adj| scaled by 2^(2F), overflow if quotient needs > EW+1 bits
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_q[0] <= in_dmag;
			dout_q[0] <= item[NUM_ENTRIES*LW +: DETW];
			sing_q[0] <= item[QIW-1];
			for (int l = 0; l < NUM_ENTRIES; l++) begin
				rem_q[0][l] <= CW'(item[l*LW +: AMW]) << (2 * F);
				quo_q[0][l] <= '0;
				neg_q[0][l] <= item[l*LW + AMW] ^ in_dneg;
				ovf_q[0][l] <= (CW'(item[l*LW +: AMW]) << (2 * F)) >=
					(CW'(in_dmag) << (EW + 1));
			end
		end
	end

	for (genvar i = 1; i < NS; i++) begin : g_stage
		localparam int K = EW + 1 - i;
		always_ff @(posedge clk) begin
			if (en) begin
				dmag_q[i] <= dmag_q[i-1];
				dout_q[i] <= dout_q[i-1];
				sing_q[i] <= sing_q[i-1];
			end
		end
		for (genvar l = 0; l < NUM_ENTRIES; l++) begin : g_lane
			logic [CW-1:0] sub;
			logic          ge;
			assign sub = CW'(dmag_q[i-1]) << K;
			assign ge  = (rem_q[i-1][l] >= sub);
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i][l] <= ge ? (rem_q[i-1][l] - sub) : rem_q[i-1][l];
					quo_q[i][l] <= quo_q[i-1][l] | (QW'(ge) << K);
					ovf_q[i][l] <= ovf_q[i-1][l];
					neg_q[i][l] <= neg_q[i-1][l];
				end
			end
		end
	end

	// saturate and apply sign, identity on a singular matrix
	logic [EW-1:0] res [NUM_ENTRIES];

	always_comb begin
		logic [QW-1:0] lim;
		logic [QW-1:0] mag;
		logic [EW-1:0] val;
		lim = LIM_P;
		mag = '0;
		val = '0;
		for (int l = 0; l < NUM_ENTRIES; l++) begin
			lim = neg_q[NS-1][l] ? LIM_N : LIM_P;
			mag = (ovf_q[NS-1][l] || (quo_q[NS-1][l] > lim)) ? lim : quo_q[NS-1][l];
			val = EW'(mag);
			if (sing_q[NS-1]) begin
				res[l] = (l % 4 == 0) ? ONE_VAL : '0;
			end else begin
				res[l] = neg_q[NS-1][l] ? -val : val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_q  <= res;
			det_q  <= sing_q[NS-1] ? '0 : dout_q[NS-1];
			sout_q <= sing_q[NS-1];
		end
	end

	assign out_valid = ov_q;
	assign det_out   = det_q;
	assign sing      = sout_q;
	for (genvar l = 0; l < NUM_ENTRIES; l++) begin : g_out
		assign inv[l] = inv_q[l];
	end

endmodule

/* hw/rtl/mat3_inverse_det_core.sv */
// 3x3 fixed-point inverse and determinant, one matrix per transfer.
// accepts one matrix per cycle while in_stall is low; out_stall can fill the queue
// and then holds off the input through in_stall.
// a matrix passes the six-stage adjugate and determinant pipeline, then the divider
// lanes, one quotient bit per stage. arst_n clears all valid and queue state.

module mat3_inverse_det_core
	import mi3_pkg::*;
#(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ENTRY_WIDTH-1:0]        a00,
	input  logic signed [ENTRY_WIDTH-1:0]        a01,
	input  logic signed [ENTRY_WIDTH-1:0]        a02,
	input  logic signed [ENTRY_WIDTH-1:0]        a10,
	input  logic signed [ENTRY_WIDTH-1:0]        a11,
	input  logic signed [ENTRY_WIDTH-1:0]        a12,
	input  logic signed [ENTRY_WIDTH-1:0]        a20,
	input  logic signed [ENTRY_WIDTH-1:0]        a21,
	input  logic signed [ENTRY_WIDTH-1:0]        a22,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ENTRY_WIDTH-1:0]        b00,
	output logic signed [ENTRY_WIDTH-1:0]        b01,
	output logic signed [ENTRY_WIDTH-1:0]        b02,
	output logic signed [ENTRY_WIDTH-1:0]        b10,
	output logic signed [ENTRY_WIDTH-1:0]        b11,
	output logic signed [ENTRY_WIDTH-1:0]        b12,
	output logic signed [ENTRY_WIDTH-1:0]        b20,
	output logic signed [ENTRY_WIDTH-1:0]        b21,
	output logic signed [ENTRY_WIDTH-1:0]        b22,
	output logic signed [ENTRY_WIDTH+FRAC_BITS-1:0] determinant,
	output logic                                 singular
);

	localparam int AMW = 2 * ENTRY_WIDTH;
	localparam int DMW = 3 * ENTRY_WIDTH + 2;
	localparam int QIW = NUM_ENTRIES * (AMW + 1) + DMW + ENTRY_WIDTH + FRAC_BITS + 2;

	logic signed [ENTRY_WIDTH-1:0] ent [NUM_ENTRIES];
	logic signed [ENTRY_WIDTH-1:0] inv [NUM_ENTRIES];
	fifo_st_t                      fst;
	logic                          push;
	logic                          pop;
	logic [QIW-1:0]                item_in;
	logic [QIW-1:0]                item_out;

	assign ent[0] = a00;
	assign ent[1] = a01;
	assign ent[2] = a02;
	assign ent[3] = a10;
	assign ent[4] = a11;
	assign ent[5] = a12;
	assign ent[6] = a20;
	assign ent[7] = a21;
	assign ent[8] = a22;

	mi3_front #(
		.EW (ENTRY_WIDTH),
		.F  (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ent      (ent),
		.st       (fst),
		.push     (push),
		.item     (item_in)
	);

	mi3_fifo #(
		.WIDTH (QIW),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (item_in),
		.pop    (pop),
		.dout   (item_out),
		.st     (fst)
	);

	mi3_back #(
		.EW (ENTRY_WIDTH),
		.F  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.st        (fst),
		.item      (item_out),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.inv       (inv),
		.det_out   (determinant),
		.sing      (singular)
	);

	assign b00 = inv[0];
	assign b01 = inv[1];
	assign b02 = inv[2];
	assign b10 = inv[3];
	assign b11 = inv[4];
	assign b12 = inv[5];
	assign b20 = inv[6];
	assign b21 = inv[7];
	assign b22 = inv[8];

	// a singular result carries a zero determinant and the identity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> determinant == '0 && b01 == '0 && b00 == b11)
		else $error("singular result without identity and zero determinant");

	// the front only holds off input when the queue is full
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> fst.full)
		else $error("input stalled while queue has room");

	// queue status is never both full and empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!(fst.full && fst.empty))
		else $error("queue status inconsistent");

endmodule
